[rtl/core/spst_pkg.sv]
// shared constants and types for the sparse page slot table
// no dependencies

package spst_pkg;

  localparam int MAX_SLOTS_DEF = 64;

  localparam int SLOT_COUNT_W = 7;
  localparam int TILE_W       = 11;
  localparam int IMAGE_W      = 15;
  localparam int PAGE_W       = 16;
  localparam int SLOT_W       = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 15;
  localparam int PROD_W       = 27;

  localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST   = 7'd64;
  localparam logic [TILE_W-1:0]       TILE_WIDTH_RST   = 11'd128;
  localparam logic [TILE_W-1:0]       TILE_HEIGHT_RST  = 11'd128;
  localparam logic [IMAGE_W-1:0]      IMAGE_WIDTH_RST  = 15'd4096;
  localparam logic [IMAGE_W-1:0]      IMAGE_HEIGHT_RST = 15'd4096;

  localparam logic [SLOT_W-1:0] SLOT_NONE = 7'h7f;
  localparam logic [PAGE_W-1:0] PAGE_NONE = 16'hffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT   = 3'd0,
    REG_TILE_WIDTH   = 3'd1,
    REG_TILE_HEIGHT  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_HIT       = 3'd1,
    ST_RANGE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_FREED     = 3'd4,
    ST_BADUNBIND = 3'd5
  } status_t;

endpackage

[rtl/core/spst_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies

module spst_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/sparse_page_slot_table_unit.sv]
// sparse page slot table: bind and unbind of virtual pages to physical slots
// depends on spst_pkg and spst_ram
// bind: a negative page is rejected from idle, a page past the image edge after the edge tests;
//   otherwise the n active slots are scanned, using one shared multiplier over four products and one ram read per slot
// unbind: an out of range slot is rejected from idle, else the slot word is read and checked; one transaction at a time
// reset: synchronous; a clearing pass over all MAX_SLOTS slots keeps busy high, config writes taken

module sparse_page_slot_table_unit #(
  parameter int MAX_SLOTS = spst_pkg::MAX_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  kind,
  input  logic signed [spst_pkg::PAGE_W-1:0]    page_col,
  input  logic signed [spst_pkg::PAGE_W-1:0]    page_row,
  input  logic signed [spst_pkg::SLOT_W-1:0]    wanted_slot,
  input  logic signed [spst_pkg::SLOT_W-1:0]    target_slot,
  output logic                                  done,
  output logic [2:0]                            status,
  output logic signed [spst_pkg::SLOT_W-1:0]    slot_index,
  output logic [spst_pkg::IMAGE_W-1:0]          pixel_x,
  output logic [spst_pkg::IMAGE_W-1:0]          pixel_y,
  input  logic                                  cfg_we,
  input  logic [spst_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spst_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW    = $clog2(MAX_SLOTS + 1);
  localparam int PW    = spst_pkg::PAGE_W;
  localparam int WORDW = 2 * PW + 1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_TAIL   = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_UREAD  = 8'b0100_0000,
    S_UCHK   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [spst_pkg::SLOT_COUNT_W-1:0] slot_count;
  logic [spst_pkg::TILE_W-1:0]       tile_width;
  logic [spst_pkg::TILE_W-1:0]       tile_height;
  logic [spst_pkg::IMAGE_W-1:0]      image_width;
  logic [spst_pkg::IMAGE_W-1:0]      image_height;

  logic [AW-1:0]   clr;
  logic [NW-1:0]   n;
  logic [NW-1:0]   n_eff;
  logic [NW-1:0]   i;
  logic            sv;
  logic [NW-1:0]   si;
  logic [PW-1:0]   col;
  logic [PW-1:0]   row;
  logic [5:0]      want;
  logic            want_ok;
  logic [5:0]      tgt;
  logic            hit_found;
  logic [NW-1:0]   hit_idx;
  logic            free_found;
  logic [NW-1:0]   free_idx;
  logic            want_free;
  logic [2:0]      ms;
  logic [spst_pkg::PROD_W-1:0] prod;
  logic [spst_pkg::IMAGE_W-1:0] px;
  logic [spst_pkg::IMAGE_W-1:0] py;

  logic [15:0]                 mul_a;
  logic [spst_pkg::TILE_W-1:0] mul_b;
  logic [spst_pkg::PROD_W-1:0] mul_out;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WORDW-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [WORDW-1:0] ram_rdata;

  logic             sel_ok;
  logic [NW-1:0]    sel_slot;
  logic [31:0]      sc32;

  spst_ram #(
    .WIDTH(WORDW),
    .DEPTH(MAX_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy = (state != S_IDLE);

  // active slot count, clamped to 1..MAX_SLOTS
  always_comb begin
    sc32 = 32'(slot_count);
    if (sc32 == 32'd0) begin
      n_eff = NW'(1);
    end else if (sc32 > 32'(MAX_SLOTS)) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = NW'(sc32);
    end
  end

  // shared multiplier: edge tests first, then pixel offsets
  always_comb begin
    case (ms)
      3'd0: begin
        mul_a = {1'b0, col[14:0]} + 16'd1;
        mul_b = tile_width;
      end
      3'd1: begin
        mul_a = {1'b0, row[14:0]} + 16'd1;
        mul_b = tile_height;
      end
      3'd2: begin
        mul_a = {1'b0, col[14:0]};
        mul_b = tile_width;
      end
      default: begin
        mul_a = {1'b0, row[14:0]};
        mul_b = tile_height;
      end
    endcase
    mul_out = {11'd0, mul_a} * {16'd0, mul_b};
  end

  always_comb begin
    sel_ok   = 1'b1;
    sel_slot = free_idx;
    if (want_ok && want_free) begin
      sel_slot = NW'(want);
    end else if (!free_found) begin
      sel_ok = 1'b0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
      end
      S_SCAN: begin
        ram_raddr = AW'(i);
      end
      S_DECIDE: begin
        if (!hit_found && sel_ok) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(sel_slot);
          ram_wdata = {1'b1, col, row};
        end
      end
      S_UREAD: begin
        ram_raddr = AW'(tgt);
      end
      S_UCHK: begin
        ram_waddr = AW'(tgt);
        ram_wdata = {1'b0, spst_pkg::PAGE_NONE, spst_pkg::PAGE_NONE};
        ram_we    = ram_rdata[WORDW-1];
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= spst_pkg::SLOT_COUNT_RST;
      tile_width   <= spst_pkg::TILE_WIDTH_RST;
      tile_height  <= spst_pkg::TILE_HEIGHT_RST;
      image_width  <= spst_pkg::IMAGE_WIDTH_RST;
      image_height <= spst_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spst_pkg::REG_SLOT_COUNT:   slot_count   <= cfg_data[spst_pkg::SLOT_COUNT_W-1:0];
        spst_pkg::REG_TILE_WIDTH:   tile_width   <= cfg_data[spst_pkg::TILE_W-1:0];
        spst_pkg::REG_TILE_HEIGHT:  tile_height  <= cfg_data[spst_pkg::TILE_W-1:0];
        spst_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        spst_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // scan results, one ram word per cycle
  always_ff @(posedge clk) begin
    if (sv) begin
      if (ram_rdata[WORDW-1] && ram_rdata[2*PW-1:PW] == col && ram_rdata[PW-1:0] == row
          && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= si;
      end
      if (!ram_rdata[WORDW-1] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= si;
      end
      if (want_ok && 32'(si) == 32'(want)) begin
        want_free <= !ram_rdata[WORDW-1];
      end
    end
    if (state == S_IDLE && start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      want_free  <= 1'b0;
      free_idx   <= '0;
      hit_idx    <= '0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
      sv    <= 1'b0;
    end else begin
      done <= 1'b0;
      sv   <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(MAX_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            col     <= page_col;
            row     <= page_row;
            want    <= wanted_slot[5:0];
            want_ok <= !wanted_slot[6] && (32'(wanted_slot[5:0]) < 32'(n_eff));
            tgt     <= target_slot[5:0];
            n       <= n_eff;
            i       <= '0;
            ms      <= 3'd0;
            if (kind) begin
              if (!target_slot[6] && (32'(target_slot[5:0]) < 32'(n_eff))) begin
                state <= S_UREAD;
              end else begin
                done       <= 1'b1;
                status     <= spst_pkg::ST_BADUNBIND;
                slot_index <= spst_pkg::SLOT_NONE;
                pixel_x    <= '0;
                pixel_y    <= '0;
              end
            end else if (page_col[PW-1] || page_row[PW-1]) begin
              done       <= 1'b1;
              status     <= spst_pkg::ST_RANGE;
              slot_index <= spst_pkg::SLOT_NONE;
              pixel_x    <= '0;
              pixel_y    <= '0;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod <= mul_out;
          ms   <= ms + 3'd1;
          if ((ms == 3'd1 && prod > 27'(image_width)) ||
              (ms == 3'd2 && prod > 27'(image_height))) begin
            done       <= 1'b1;
            status     <= spst_pkg::ST_RANGE;
            slot_index <= spst_pkg::SLOT_NONE;
            pixel_x    <= '0;
            pixel_y    <= '0;
            state      <= S_IDLE;
          end else if (ms == 3'd3) begin
            px <= prod[spst_pkg::IMAGE_W-1:0];
          end else if (ms == 3'd4) begin
            py    <= prod[spst_pkg::IMAGE_W-1:0];
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          sv <= 1'b1;
          si <= i;
          i  <= i + NW'(1);
          if (i == n - NW'(1)) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (hit_found) begin
            status     <= spst_pkg::ST_HIT;
            slot_index <= 7'(hit_idx);
            pixel_x    <= px;
            pixel_y    <= py;
          end else if (sel_ok) begin
            status     <= spst_pkg::ST_NEW;
            slot_index <= 7'(sel_slot);
            pixel_x    <= px;
            pixel_y    <= py;
          end else begin
            status     <= spst_pkg::ST_FULL;
            slot_index <= spst_pkg::SLOT_NONE;
            pixel_x    <= '0;
            pixel_y    <= '0;
          end
        end
        S_UREAD: begin
          state <= S_UCHK;
        end
        S_UCHK: begin
          done    <= 1'b1;
          state   <= S_IDLE;
          pixel_x <= '0;
          pixel_y <= '0;
          if (ram_rdata[WORDW-1]) begin
            status     <= spst_pkg::ST_FREED;
            slot_index <= {1'b0, tgt};
          end else begin
            status     <= spst_pkg::ST_BADUNBIND;
            slot_index <= spst_pkg::SLOT_NONE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither in progress nor finished");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (rst)
    (done && (status == spst_pkg::ST_RANGE || status == spst_pkg::ST_FULL ||
              status == spst_pkg::ST_BADUNBIND)) |-> (slot_index == spst_pkg::SLOT_NONE))
    else $error("failed transaction reports a slot");

  a_fail_no_pixels: assert property (@(posedge clk) disable iff (rst)
    (done && status != spst_pkg::ST_NEW && status != spst_pkg::ST_HIT)
      |-> (pixel_x == '0 && pixel_y == '0))
    else $error("pixel offset on a transaction without a bound page");

  a_ok_slot_valid: assert property (@(posedge clk) disable iff (rst)
    (done && (status == spst_pkg::ST_NEW || status == spst_pkg::ST_HIT ||
              status == spst_pkg::ST_FREED)) |-> !slot_index[spst_pkg::SLOT_W-1])
    else $error("successful transaction without a slot");
`endif

endmodule

[sim/tb_sparse_page_slot_table_unit.sv]
`timescale 1ns / 100ps
// testbench for sparse_page_slot_table_unit: directed and random bind and unbind transactions,
// each result checked against a behavioral slot table kept in the bench
// depends on spst_pkg and the sparse_page_slot_table_unit rtl

module tb_sparse_page_slot_table_unit;
  import spst_pkg::*;

  typedef struct {
    logic                     kind;
    logic signed [PAGE_W-1:0] col;
    logic signed [PAGE_W-1:0] row;
    logic signed [SLOT_W-1:0] want;
    logic signed [SLOT_W-1:0] tgt;
  } page_req_t;

  typedef struct {
    status_t                  st;
    logic signed [SLOT_W-1:0] slot;
    logic [IMAGE_W-1:0]       px;
    logic [IMAGE_W-1:0]       py;
  } slot_reply_t;

  localparam int   SLOTS       = MAX_SLOTS_DEF;
  localparam logic KIND_BIND   = 1'b0;
  localparam logic KIND_UNBIND = 1'b1;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     kind = KIND_BIND;
  logic signed [PAGE_W-1:0] page_col = '0;
  logic signed [PAGE_W-1:0] page_row = '0;
  logic signed [SLOT_W-1:0] wanted_slot = SLOT_NONE;
  logic signed [SLOT_W-1:0] target_slot = SLOT_NONE;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     busy;
  logic                     done;
  logic [2:0]               status;
  logic signed [SLOT_W-1:0] slot_index;
  logic [IMAGE_W-1:0]       pixel_x;
  logic [IMAGE_W-1:0]       pixel_y;

  // table image kept by the bench
  logic [SLOT_COUNT_W-1:0] tbl_slot_count = SLOT_COUNT_RST;
  logic [TILE_W-1:0]       tbl_tile_w = TILE_WIDTH_RST;
  logic [TILE_W-1:0]       tbl_tile_h = TILE_HEIGHT_RST;
  logic [IMAGE_W-1:0]      tbl_image_w = IMAGE_WIDTH_RST;
  logic [IMAGE_W-1:0]      tbl_image_h = IMAGE_HEIGHT_RST;
  bit                      tbl_bound [SLOTS];
  bit [PAGE_W-1:0]         tbl_col [SLOTS];
  bit [PAGE_W-1:0]         tbl_row [SLOTS];

  page_req_t   req_queue [$];
  slot_reply_t reply_queue [$];
  logic        req_taken = 1'b0;
  int          sent_count = 0;
  int          recv_count = 0;
  int          mismatch_count = 0;

  sparse_page_slot_table_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int active_count();
    if (tbl_slot_count == 0) return 1;
    if (tbl_slot_count > SLOTS) return SLOTS;
    return tbl_slot_count;
  endfunction

  function automatic slot_reply_t resolve_request(page_req_t r);
    slot_reply_t res;
    int n, c, rw, w, t, i, tw, th, pxv, pyv, pick;
    res.st = ST_BADUNBIND;
    res.slot = SLOT_NONE;
    res.px = '0;
    res.py = '0;
    n = active_count();
    if (r.kind == KIND_UNBIND) begin
      t = r.tgt;
      if (t >= 0 && t < n && tbl_bound[t]) begin
        tbl_bound[t] = 1'b0;
        tbl_col[t] = PAGE_NONE;
        tbl_row[t] = PAGE_NONE;
        res.st = ST_FREED;
        res.slot = r.tgt;
      end
      return res;
    end
    c = r.col;
    rw = r.row;
    w = r.want;
    tw = tbl_tile_w;
    th = tbl_tile_h;
    res.st = ST_RANGE;
    if (c < 0 || rw < 0) return res;
    if ((c + 1) * tw > int'(tbl_image_w) || (rw + 1) * th > int'(tbl_image_h)) return res;
    pxv = c * tw;
    pyv = rw * th;
    for (i = 0; i < n; i++) begin
      if (tbl_bound[i] && tbl_col[i] == r.col && tbl_row[i] == r.row) begin
        res.st = ST_HIT;
        res.slot = SLOT_W'(i);
        res.px = pxv[IMAGE_W-1:0];
        res.py = pyv[IMAGE_W-1:0];
        return res;
      end
    end
    pick = -1;
    if (w >= 0 && w < n && !tbl_bound[w]) begin
      pick = w;
    end else begin
      for (i = n - 1; i >= 0; i--) begin
        if (!tbl_bound[i]) pick = i;
      end
    end
    if (pick < 0) begin
      res.st = ST_FULL;
      return res;
    end
    tbl_bound[pick] = 1'b1;
    tbl_col[pick] = r.col;
    tbl_row[pick] = r.row;
    res.st = ST_NEW;
    res.slot = SLOT_W'(pick);
    res.px = pxv[IMAGE_W-1:0];
    res.py = pyv[IMAGE_W-1:0];
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  // request driver
  always @(negedge clk) begin : drive_requests
    page_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (req_queue.size() > 0 &&
          !((sent_count < 400 || sent_count >= 600) && $urandom_range(99) < 7)) begin
        nxt = req_queue.pop_front();
        kind <= nxt.kind;
        page_col <= nxt.col;
        page_row <= nxt.row;
        wanted_slot <= nxt.want;
        target_slot <= nxt.tgt;
        start <= 1'b1;
        sent_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_replies
    slot_reply_t exp_r;
    page_req_t acc;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (done) begin
        recv_count++;
        if (reply_queue.size() == 0) begin
          log_mismatch($sformatf("unexpected result: status %0d slot %0d x %0d y %0d",
                                 status, slot_index, pixel_x, pixel_y));
        end else begin
          exp_r = reply_queue.pop_front();
          if (status !== exp_r.st || slot_index !== exp_r.slot ||
              pixel_x !== exp_r.px || pixel_y !== exp_r.py)
            log_mismatch($sformatf({"mismatch: expected status %0d slot %0d x %0d y %0d, ",
                                    "got status %0d slot %0d x %0d y %0d"},
                                   exp_r.st, exp_r.slot, exp_r.px, exp_r.py,
                                   status, slot_index, pixel_x, pixel_y));
        end
      end
      if (start && !busy) begin
        acc.kind = kind;
        acc.col = page_col;
        acc.row = page_row;
        acc.want = wanted_slot;
        acc.tgt = target_slot;
        reply_queue.push_back(resolve_request(acc));
      end
    end
  end

  task automatic program_reg(input cfg_reg_t r, input int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= CFG_DATA_W'(v);
    case (r)
      REG_SLOT_COUNT:   tbl_slot_count = SLOT_COUNT_W'(v);
      REG_TILE_WIDTH:   tbl_tile_w = TILE_W'(v);
      REG_TILE_HEIGHT:  tbl_tile_h = TILE_W'(v);
      REG_IMAGE_WIDTH:  tbl_image_w = IMAGE_W'(v);
      REG_IMAGE_HEIGHT: tbl_image_h = IMAGE_W'(v);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_table(input int sc, input int tw, input int th, input int iw,
                           input int ih);
    program_reg(REG_SLOT_COUNT, sc);
    program_reg(REG_TILE_WIDTH, tw);
    program_reg(REG_TILE_HEIGHT, th);
    program_reg(REG_IMAGE_WIDTH, iw);
    program_reg(REG_IMAGE_HEIGHT, ih);
  endtask

  // every sent transaction has its result back and the block is idle
  task automatic wait_drain();
    while (req_queue.size() != 0 || sent_count != recv_count || start || busy)
      @(negedge clk);
  endtask

  task automatic push_bind(input int col, input int row, input int want);
    page_req_t q;
    q.kind = KIND_BIND;
    q.col = PAGE_W'(col);
    q.row = PAGE_W'(row);
    q.want = SLOT_W'(want);
    q.tgt = SLOT_W'($urandom);
    req_queue.push_back(q);
  endtask

  task automatic push_unbind(input int tgt);
    page_req_t q;
    q.kind = KIND_UNBIND;
    q.col = PAGE_W'($urandom);
    q.row = PAGE_W'($urandom);
    q.want = SLOT_W'($urandom);
    q.tgt = SLOT_W'(tgt);
    req_queue.push_back(q);
  endtask

  function automatic logic signed [PAGE_W-1:0] pick_coord(input int lim, input int span);
    int sel, v;
    sel = $urandom_range(99);
    if (sel < 75) begin
      v = (lim >= 0) ? $urandom_range(0, (lim < span) ? lim : span) : $urandom_range(0, span);
    end else if (sel < 85) begin
      v = lim + $urandom_range(0, 1);
    end else if (sel < 92) begin
      v = -int'($urandom_range(1, 32768));
    end else begin
      v = $urandom;
    end
    return PAGE_W'(v);
  endfunction

  function automatic page_req_t random_request(input int span);
    page_req_t q;
    int n, lim_c, lim_r, sel;
    n = active_count();
    lim_c = (tbl_tile_w == 0) ? 32767 : int'(tbl_image_w) / int'(tbl_tile_w) - 1;
    lim_r = (tbl_tile_h == 0) ? 32767 : int'(tbl_image_h) / int'(tbl_tile_h) - 1;
    q.kind = ($urandom_range(99) < 35) ? KIND_UNBIND : KIND_BIND;
    q.col = pick_coord(lim_c, span);
    q.row = pick_coord(lim_r, span);
    sel = $urandom_range(9);
    if (sel < 4) q.want = SLOT_NONE;
    else if (sel < 8) q.want = SLOT_W'($urandom_range(0, n - 1));
    else q.want = SLOT_W'($urandom);
    sel = $urandom_range(9);
    if (sel < 8) q.tgt = SLOT_W'($urandom_range(0, n - 1));
    else if (sel == 8) q.tgt = (n < SLOTS) ? SLOT_W'($urandom_range(n, SLOTS - 1)) : SLOT_NONE;
    else q.tgt = SLOT_W'($urandom);
    return q;
  endfunction

  function automatic int tile_pick();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return 0;
    if (sel < 16) return 2047;
    if (sel < 24) return 1;
    return $urandom_range(2, 512);
  endfunction

  function automatic int image_pick(input int tile);
    int sel, v;
    sel = $urandom_range(99);
    if (sel < 6) return 0;
    if (sel < 12) return 32767;
    v = tile * $urandom_range(1, 24) + $urandom_range(0, 3);
    return (v > 32767) ? 32767 : v;
  endfunction

  initial begin : stimulus
    int p, k, sc, tw, th, span;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset geometry: 128 pixel tiles over a 4096 image
    push_bind(0, 0, -1);
    push_bind(0, 0, 5);
    push_bind(31, 31, 63);
    push_bind(32, 0, -1);
    push_bind(-1, 0, -1);
    push_bind(0, -32768, -1);
    push_bind(32767, 32767, -64);
    push_bind(1, 2, 63);
    push_unbind(63);
    push_unbind(63);
    push_unbind(-1);
    push_unbind(-64);
    wait_drain();

    // two slots: out of range page, slot above count
    set_table(2, 16, 8, 100, 50);
    push_bind(5, 5, -1);
    push_bind(6, 0, -1);
    push_unbind(2);
    push_unbind(1);
    push_bind(5, 5, 1);
    wait_drain();

    // zero tile and image, count of zero acts as one, shrunk slots ignored
    set_table(0, 0, 0, 0, 0);
    push_bind(32767, 32767, -1);
    push_bind(0, 0, -1);
    push_unbind(1);
    push_unbind(0);
    push_bind(32767, 32767, 0);
    wait_drain();

    set_table(127, 2047, 2047, 32767, 32767);
    push_bind(15, 15, 63);
    push_bind(16, 0, -1);
    wait_drain();

    set_table(64, 1, 1, 0, 0);
    push_bind(0, 0, -1);
    wait_drain();

    for (p = 0; p < 10; p++) begin
      case ($urandom_range(9))
        0: sc = 0;
        1: sc = 1;
        2: sc = 2;
        3: sc = 4;
        4: sc = 127;
        5: sc = 64;
        default: sc = $urandom_range(1, 16);
      endcase
      tw = tile_pick();
      th = tile_pick();
      set_table(sc, tw, th, image_pick(tw), image_pick(th));
      span = $urandom_range(1, 10);
      for (k = 0; k < 100; k++) req_queue.push_back(random_request(span));
      wait_drain();
    end

    repeat (80) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
